// ===== hw/rtl/qwt_pkg.sv =====
// Shared types and constants for the quoted word tokenizer.
`timescale 1ns / 1ps

package qwt_pkg;

  localparam int MAX_WORD = 256;
  localparam int LEN_W    = $clog2(MAX_WORD + 2);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_WORD = 2'd1;
  localparam logic [1:0] EV_LIST = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Results caused by one request, always emitted in field order:
  // character, end of word, end of list.
  typedef struct packed {
    logic       do_char;
    logic [7:0] ch;
    logic       do_word;
    logic       trunc;
    logic       do_list;
  } cmd_t;

endpackage

// ===== hw/rtl/quoted_word_tokenizer_unit.sv =====
// Top level of the quoted word tokenizer.
`timescale 1ns / 1ps

// Splits a byte stream into words, one input byte per request. The front end
// takes one request per clock as long as its four-entry command queue has
// room, and turns it into up to three results (character, end of word, end of
// list). The back end delivers one result per clock through an output
// register while that register is empty or popped; a request causes 0 to 3
// results. Whitespace between words writes nothing to the command queue.
// Words are capped at MAX_WORD characters; extra characters are dropped and
// the end of word is flagged truncated.

module quoted_word_tokenizer_unit
  import qwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_kind,
  input  logic [7:0] in_byte_req,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_event_res,
  output logic [7:0] out_byte,
  output logic       out_truncated,
  output logic       out_last
);

  logic cmd_wr;
  cmd_t cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  qwt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_kind     (in_kind),
    .in_byte_req (in_byte_req),
    .cmd_wr      (cmd_wr),
    .cmd         (cmd)
  );

  qwt_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmd_wr),
    .wdata (cmd),
    .rd    (q_pop),
    .rdata (q_head),
    .full  (full),
    .empty (q_empty)
  );

  qwt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_event_res (out_event_res),
    .out_byte      (out_byte),
    .out_truncated (out_truncated),
    .out_last      (out_last)
  );

endmodule

// ===== hw/rtl/qwt_front.sv =====
// Front end: classifies each input byte and tracks the word/quote state.
`timescale 1ns / 1ps

module qwt_front
  import qwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic       in_kind,
  input  logic [7:0] in_byte_req,
  output logic       cmd_wr,
  output cmd_t       cmd
);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_PLAIN  = 2'd1;
  localparam logic [1:0] PH_QUOTED = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);
  localparam logic [LEN_W-1:0] LEN_OVF = LEN_W'(MAX_WORD + 1);

  logic [1:0]       phase_r, phase_nxt;
  logic             qs_r, qs_nxt;
  logic             esc_r, esc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             accept;
  logic             line_end;
  logic             is_ws;
  logic [7:0]       quote;
  logic             ap_char;
  logic [LEN_W-1:0] ap_len;
  logic             cl_char;
  logic [LEN_W-1:0] cl_len;
  logic             cl_empty;
  logic             cl_trunc;

  assign accept   = push && !full;
  assign line_end = in_kind || (in_byte_req == CH_NUL) || (in_byte_req == CH_LF);
  assign is_ws    = (in_byte_req == CH_SPACE) ||
                    ((in_byte_req >= CH_TAB) && (in_byte_req <= CH_CR));
  assign quote    = qs_r ? CH_SQUOTE : CH_DQUOTE;

  // append one character to the word
  assign ap_char  = len_r < LEN_MAX;
  assign ap_len   = ap_char ? len_r + LEN_W'(1) : LEN_OVF;

  // close the word: flush a pending backslash first
  assign cl_char  = esc_r && ap_char;
  assign cl_len   = esc_r ? ap_len : len_r;
  assign cl_empty = (phase_r == PH_QUOTED) && (cl_len == '0);
  assign cl_trunc = cl_len > LEN_MAX;

  always_comb begin
    phase_nxt = phase_r;
    qs_nxt    = qs_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    cmd       = '0;
    cmd.ch    = in_byte_req;
    if (line_end) begin
      case (phase_r)
        PH_SKIP: begin
          cmd.do_list = 1'b1;
        end
        PH_PLAIN, PH_QUOTED: begin
          cmd.do_char = cl_char;
          cmd.ch      = CH_BSLASH;
          cmd.do_word = !cl_empty;
          cmd.trunc   = cl_trunc;
          cmd.do_list = 1'b1;
        end
        default: begin
        end
      endcase
      phase_nxt = PH_SKIP;
      qs_nxt    = 1'b0;
      esc_nxt   = 1'b0;
      len_nxt   = '0;
    end else begin
      case (phase_r)
        PH_SKIP: begin
          if (is_ws) begin
          end else if ((in_byte_req == CH_DQUOTE) || (in_byte_req == CH_SQUOTE)) begin
            phase_nxt = PH_QUOTED;
            qs_nxt    = (in_byte_req == CH_SQUOTE);
            esc_nxt   = 1'b0;
            len_nxt   = '0;
          end else begin
            phase_nxt   = PH_PLAIN;
            esc_nxt     = 1'b0;
            len_nxt     = LEN_W'(1);
            cmd.do_char = 1'b1;
          end
        end
        PH_PLAIN: begin
          if (is_ws) begin
            cmd.do_char = cl_char;
            cmd.ch      = CH_BSLASH;
            cmd.do_word = 1'b1;
            cmd.trunc   = cl_trunc;
            esc_nxt     = 1'b0;
            len_nxt     = cl_len;
            phase_nxt   = PH_SKIP;
          end else begin
            cmd.do_char = ap_char;
            len_nxt     = ap_len;
          end
        end
        PH_QUOTED: begin
          if ((in_byte_req == CH_BSLASH) && !esc_r) begin
            esc_nxt = 1'b1;
          end else if ((in_byte_req == CH_CR) || (!esc_r && (in_byte_req == quote))) begin
            cmd.do_char = cl_char;
            cmd.ch      = CH_BSLASH;
            cmd.do_word = !cl_empty;
            cmd.trunc   = cl_trunc;
            cmd.do_list = cl_empty;
            len_nxt     = cl_len;
            esc_nxt     = 1'b0;
            phase_nxt   = cl_empty ? PH_DONE : PH_SKIP;
          end else begin
            esc_nxt     = 1'b0;
            cmd.do_char = ap_char;
            len_nxt     = ap_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_wr = accept && (cmd.do_char || cmd.do_word || cmd.do_list);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      qs_r    <= 1'b0;
      esc_r   <= 1'b0;
      len_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      qs_r    <= qs_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== hw/rtl/qwt_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module qwt_cmd_fifo
  import qwt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wdata,
  input  logic rd,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_r, wp_nxt;
  logic [CQ_AW-1:0] rp_r, rp_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = cnt_r == CQ_CW'(CQ_DEPTH);
  assign empty = cnt_r == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + CQ_AW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + CQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/qwt_back.sv =====
// Back end: expands queued commands into one result per cycle while the output register is empty or popped.
`timescale 1ns / 1ps

module qwt_back
  import qwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_event_res,
  output logic [7:0] out_byte,
  output logic       out_truncated,
  output logic       out_last
);

  // rem bits: [0] character, [1] end of word, [2] end of list
  logic [2:0] rem_r, rem_nxt;
  cmd_t       cur_r;
  logic       ov_r, ov_nxt;
  logic [1:0] ev_r;
  logic [7:0] byte_r;
  logic       trunc_r;
  logic       last_r;

  logic       adv;
  logic       emit;
  logic [2:0] sel;
  logic [2:0] rem_left;

  always_comb begin
    adv = !ov_r || pop;
    if (rem_r[0]) begin
      sel = 3'b001;
    end else if (rem_r[1]) begin
      sel = 3'b010;
    end else if (rem_r[2]) begin
      sel = 3'b100;
    end else begin
      sel = 3'b000;
    end
    emit     = adv && (rem_r != 3'b000);
    rem_left = emit ? (rem_r & ~sel) : rem_r;
    q_pop    = (rem_left == 3'b000) && !q_empty;
    rem_nxt  = q_pop ? {q_head.do_list, q_head.do_word, q_head.do_char} : rem_left;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (emit) begin
      ev_r    <= sel[0] ? EV_CHAR : (sel[1] ? EV_WORD : EV_LIST);
      byte_r  <= sel[0] ? cur_r.ch : 8'h00;
      trunc_r <= sel[1] && cur_r.trunc;
      last_r  <= rem_left == 3'b000;
    end
  end

  assign empty         = !ov_r;
  assign out_event_res = ev_r;
  assign out_byte      = byte_r;
  assign out_truncated = trunc_r;
  assign out_last      = last_r;

endmodule

// ===== hw/rtl/qwt_checker.sv =====
// Port-level checks for the quoted word tokenizer, bound to the top level.
`timescale 1ns / 1ps

module qwt_checker
  import qwt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_event_res,
  input logic [7:0] out_byte,
  input logic       out_truncated,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_event_res) && $stable(out_byte) &&
                          $stable(out_truncated) && $stable(out_last)))
    else $error("waiting result changed before pop");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_event_res != EV_CHAR)) |-> (out_byte == 8'h00))
    else $error("nonzero byte on end event");

  a_trunc_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_truncated) |-> (out_event_res == EV_WORD))
    else $error("truncated flag outside end of word");

  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_event_res == EV_LIST)) |-> out_last)
    else $error("end of list not last result of its request");

endmodule

bind quoted_word_tokenizer_unit qwt_checker u_qwt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_event_res (out_event_res),
  .out_byte      (out_byte),
  .out_truncated (out_truncated),
  .out_last      (out_last)
);
